// ===== src/kdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// kdhr_pkg - shared types and constants for the key debouncer
// Holds the transfer structs, the channel entry layout, register indexes
// and event codes used by every module of the block.
// ----------------------------------------------------------------------------
package kdhr_pkg;

    // Default sizing
    localparam int NUM_CHANNELS_DEF = 64;
    localparam int LINE_COUNT_DEF   = 8;

    // Configuration register indexes
    localparam logic [2:0] CFG_SOURCE_HANDLE = 3'd0;
    localparam logic [2:0] CFG_SETTLE_MS     = 3'd1;
    localparam logic [2:0] CFG_REPEAT_MS     = 3'd2;
    localparam logic [2:0] CFG_KIND_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_NUM_ROWS      = 3'd4;
    localparam logic [2:0] CFG_COLUMN_COUNT  = 3'd5;

    // Configuration reset values
    localparam logic [2:0]  RST_SOURCE_HANDLE = 3'd0;
    localparam logic [15:0] RST_SETTLE_MS     = 16'd20;
    localparam logic [15:0] RST_REPEAT_MS     = 16'd0;
    localparam logic [2:0]  RST_KIND_ENABLE   = 3'd7;
    localparam logic [3:0]  RST_NUM_ROWS      = 4'd8;
    localparam logic [3:0]  RST_COLUMN_COUNT  = 4'd0;

    // Event kinds
    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_UP   = 2'd1;
    localparam logic [1:0] EV_HELD = 2'd2;

    // One raw key sample
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  column;
        logic        pressed;
        logic [31:0] now_ms;
    } t_in_item;

    // One key event
    typedef struct packed {
        logic [2:0]  source;
        logic [1:0]  event_kind;
        logic [2:0]  out_row;
        logic [2:0]  out_column;
        logic        column_present;
        logic [31:0] event_tick;
        logic [31:0] press_span;
    } t_out_item;

    // Configuration register file contents
    typedef struct packed {
        logic [2:0]  source_handle;
        logic [15:0] settle_ms;
        logic [15:0] repeat_ms;
        logic [2:0]  kind_enable;
        logic [3:0]  num_rows;
        logic [3:0]  column_count;
    } t_cfg;

    // Sample prepared for the update stage
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  column;
        logic        matrix;
        logic        pressed;
        logic [31:0] now_ms;
        logic [31:0] next_repeat_ms;
    } t_stage;

    // Per-channel state kept in memory; the initialized flag lives in flops
    typedef struct packed {
        logic        stable;
        logic        raw;
        logic [31:0] last_change;
        logic [31:0] press_start;
        logic [31:0] next_repeat;
    } t_entry;

endpackage

// ===== src/kdhr_mem.sv =====
// ----------------------------------------------------------------------------
// kdhr_mem - channel state memory
// Single write port, one registered read port. A write to the address being
// read in the same cycle is forwarded into the read register.
// ----------------------------------------------------------------------------
module kdhr_mem
    import kdhr_pkg::*;
#(
    parameter int DEPTH  = NUM_CHANNELS_DEF,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    // Write back the updated entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read with write-first forwarding on an address match
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd <= i_wr_data;
            end else begin
                r_rd <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== src/kdhr_front.sv =====
// ----------------------------------------------------------------------------
// kdhr_front - sample decode
// Checks the sample against the configured rows and columns, forms the
// channel index and precomputes the next repeat tick.
// ----------------------------------------------------------------------------
module kdhr_front
    import kdhr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LINE_COUNT   = LINE_COUNT_DEF,
    parameter int IDX_W        = 6
) (
    input  t_cfg             i_cfg,
    input  t_in_item         i_item,
    output logic             o_in_range,
    output logic [IDX_W-1:0] o_idx,
    output t_stage           o_stage
);

    localparam logic [4:0] LINE_LIM = 5'(LINE_COUNT);
    localparam logic [8:0] CHAN_LIM = 9'(NUM_CHANNELS);

    logic       matrix;
    logic       row_ok;
    logic       col_ok;
    logic [8:0] idx_full;

    // Range checks and channel index
    always_comb begin
        matrix   = (i_cfg.column_count != 4'd0);
        row_ok   = ({1'b0, i_item.row} < i_cfg.num_rows) &&
                   ({2'b00, i_item.row} < LINE_LIM);
        col_ok   = ({1'b0, i_item.column} < i_cfg.column_count) &&
                   ({2'b00, i_item.column} < LINE_LIM);
        if (matrix) begin
            idx_full = 9'(i_item.column) * 9'(i_cfg.num_rows) + 9'(i_item.row);
        end else begin
            idx_full = 9'(i_item.row);
        end
        o_in_range = row_ok && (!matrix || col_ok) && (idx_full < CHAN_LIM);
        o_idx      = idx_full[IDX_W-1:0];
    end

    // Prepare the stage payload
    always_comb begin
        o_stage.row            = i_item.row;
        o_stage.column         = matrix ? i_item.column : 3'd0;
        o_stage.matrix         = matrix;
        o_stage.pressed        = i_item.pressed;
        o_stage.now_ms         = i_item.now_ms;
        o_stage.next_repeat_ms = i_item.now_ms + {16'd0, i_cfg.repeat_ms};
    end

endmodule

// ===== src/kdhr_update.sv =====
// ----------------------------------------------------------------------------
// kdhr_update - debounce and repeat decision
// Takes the stored entry of one channel and the new sample, returns the
// entry to write back and the event to raise, if any.
// ----------------------------------------------------------------------------
module kdhr_update
    import kdhr_pkg::*;
(
    input  t_cfg      i_cfg,
    input  t_stage    i_stage,
    input  logic      i_init,
    input  t_entry    i_entry,
    output t_entry    o_entry,
    output logic      o_emit,
    output t_out_item o_event
);

    logic [31:0] since_change;
    logic [31:0] since_press;
    logic [31:0] to_repeat;
    logic        fire;
    logic [1:0]  kind;
    logic [31:0] duration;

    // Tick differences, all modulo 2^32
    always_comb begin
        since_change = i_stage.now_ms - i_entry.last_change;
        since_press  = i_stage.now_ms - i_entry.press_start;
        to_repeat    = i_stage.now_ms - i_entry.next_repeat;
    end

    // Update the channel state and pick the event
    always_comb begin
        o_entry  = i_entry;
        fire     = 1'b0;
        kind     = EV_DOWN;
        duration = 32'd0;
        if (!i_init) begin
            // seed the channel without an event
            o_entry.stable      = i_stage.pressed;
            o_entry.raw         = i_stage.pressed;
            o_entry.last_change = i_stage.now_ms;
            if (i_stage.pressed) begin
                o_entry.press_start = i_stage.now_ms;
                o_entry.next_repeat = i_stage.next_repeat_ms;
            end
        end else if (i_entry.raw != i_stage.pressed) begin
            // level moved: restart the debounce timer
            o_entry.raw         = i_stage.pressed;
            o_entry.last_change = i_stage.now_ms;
        end else if (i_entry.stable != i_stage.pressed) begin
            if (since_change >= {16'd0, i_cfg.settle_ms}) begin
                o_entry.stable = i_stage.pressed;
                fire           = 1'b1;
                if (i_stage.pressed) begin
                    o_entry.press_start = i_stage.now_ms;
                    o_entry.next_repeat = i_stage.next_repeat_ms;
                    kind                = EV_DOWN;
                end else begin
                    kind     = EV_UP;
                    duration = since_press;
                end
            end
        end else if (i_entry.stable && (i_cfg.repeat_ms != 16'd0) && !to_repeat[31]) begin
            // held key: schedule the next repeat
            o_entry.next_repeat = i_stage.next_repeat_ms;
            fire                = 1'b1;
            kind                = EV_HELD;
            duration            = since_press;
        end
    end

    // Filter by the enable bits and build the event
    always_comb begin
        o_emit                 = fire && i_cfg.kind_enable[kind];
        o_event.source         = i_cfg.source_handle;
        o_event.event_kind     = kind;
        o_event.out_row        = i_stage.row;
        o_event.out_column     = i_stage.column;
        o_event.column_present = i_stage.matrix;
        o_event.event_tick     = i_stage.now_ms;
        o_event.press_span     = duration;
    end

endmodule

// ===== src/key_debounce_hold_repeat.sv =====
// ----------------------------------------------------------------------------
// key_debounce_hold_repeat - per-channel key debouncer with auto-repeat
// Debounces raw keypad samples per channel and raises DOWN, UP and HELD
// events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one raw sample (row, column,
//   level, millisecond tick). Output channel: o_out_valid / i_out_stall carry
//   one event. Configuration: i_cfg_valid / o_cfg_ready write the register
//   selected by i_cfg_index; write only while no sample is in flight.
//   Path: a transferred sample is registered in the update stage, and its
//   event is then loaded into the output register. Samples that raise no
//   event, or lie outside the configured rows and columns, produce nothing.
//   Throughput: one sample per cycle unless the input stalls, set by the single
//   read-modify-write of the channel memory (read in the transfer cycle, written
//   back as the update stage advances, forwarded between same-channel samples).
//   Reset: registers return to their defaults and every channel is marked
//   uninitialized at once; no clearing pass is needed.
//   Output stall: a pending event is held; the update stage keeps moving for
//   samples that raise no event, and the input stalls only when an event
//   finds the output register full and stalled.
// ----------------------------------------------------------------------------
module key_debounce_hold_repeat
    import kdhr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int LINE_COUNT   = LINE_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_cfg                    r_cfg;
    logic [NUM_CHANNELS-1:0] r_init;
    logic                    r_s1_valid;
    logic [IDX_W-1:0]        r_s1_idx;
    t_stage                  r_s1;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    in_range;
    logic [IDX_W-1:0]        front_idx;
    t_stage                  front_stage;
    logic                    accept;
    logic                    load_s1;
    logic                    s1_adv;
    t_entry                  rd_entry;
    t_entry                  n_entry;
    logic                    upd_emit;
    t_out_item               upd_event;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_handle <= RST_SOURCE_HANDLE;
            r_cfg.settle_ms     <= RST_SETTLE_MS;
            r_cfg.repeat_ms     <= RST_REPEAT_MS;
            r_cfg.kind_enable   <= RST_KIND_ENABLE;
            r_cfg.num_rows      <= RST_NUM_ROWS;
            r_cfg.column_count  <= RST_COLUMN_COUNT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SOURCE_HANDLE: r_cfg.source_handle <= i_cfg_data[2:0];
                CFG_SETTLE_MS:     r_cfg.settle_ms     <= i_cfg_data;
                CFG_REPEAT_MS:     r_cfg.repeat_ms     <= i_cfg_data;
                CFG_KIND_ENABLE:   r_cfg.kind_enable   <= i_cfg_data[2:0];
                CFG_NUM_ROWS:      r_cfg.num_rows      <= i_cfg_data[3:0];
                CFG_COLUMN_COUNT:  r_cfg.column_count  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Decode the incoming sample
    kdhr_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .LINE_COUNT   (LINE_COUNT),
        .IDX_W        (IDX_W)
    ) u_front (
        .i_cfg      (r_cfg),
        .i_item     (i_in_data),
        .o_in_range (in_range),
        .o_idx      (front_idx),
        .o_stage    (front_stage)
    );

    // Handshake: the update stage drains unless its event finds the output blocked
    assign s1_adv     = r_s1_valid && (!upd_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign load_s1    = accept && in_range;

    // Channel state memory
    kdhr_mem #(
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (load_s1),
        .i_rd_addr (front_idx),
        .o_rd_data (rd_entry),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_idx),
        .i_wr_data (n_entry)
    );

    // Update stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load_s1) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1_idx <= front_idx;
            r_s1     <= front_stage;
        end
    end

    // Mark channels initialized on write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (s1_adv) begin
            r_init[r_s1_idx] <= 1'b1;
        end
    end

    // Debounce and repeat decision
    kdhr_update u_update (
        .i_cfg   (r_cfg),
        .i_stage (r_s1),
        .i_init  (r_init[r_s1_idx]),
        .i_entry (rd_entry),
        .o_entry (n_entry),
        .o_emit  (upd_emit),
        .o_event (upd_event)
    );

    // Output register: hold while stalled, load on a new event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && upd_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && upd_emit) begin
            r_out <= upd_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== bench/tb_key_debounce_hold_repeat.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_debounce_hold_repeat - self-checking bench for the key debouncer
// Drives raw key samples through the input channel and predicts every DOWN,
// UP and HELD event from a per-channel debounce model in the bench. Each
// event taken from the output channel is checked field by field against the
// oldest prediction. Runs a directed opening, then random phases under
// several register settings and idling patterns, with one long output
// hold-off and one sender pause.
// ----------------------------------------------------------------------------
module tb_key_debounce_hold_repeat
    import kdhr_pkg::*;
();

    localparam int CHANNELS    = NUM_CHANNELS_DEF;
    localparam int LINES       = LINE_COUNT_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_WAIT = 6;

    // Debounce predictor and store of the events still to arrive
    class key_event_board;
        bit [2:0]  handle;
        bit [15:0] settle_ms;
        bit [15:0] repeat_ms;
        bit [2:0]  enables;
        bit [3:0]  rows;
        bit [3:0]  cols;
        bit        seen       [CHANNELS];
        bit        level      [CHANNELS];
        bit        latest     [CHANNELS];
        bit [31:0] changed_at [CHANNELS];
        bit [31:0] pressed_at [CHANNELS];
        bit [31:0] repeat_at  [CHANNELS];
        t_out_item pending_events [$];
        int        failures;

        function new();
            handle    = RST_SOURCE_HANDLE;
            settle_ms = RST_SETTLE_MS;
            repeat_ms = RST_REPEAT_MS;
            enables   = RST_KIND_ENABLE;
            rows      = RST_NUM_ROWS;
            cols      = RST_COLUMN_COUNT;
            failures  = 0;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [15:0] data);
            case (idx)
                CFG_SOURCE_HANDLE: handle    = data[2:0];
                CFG_SETTLE_MS:     settle_ms = data;
                CFG_REPEAT_MS:     repeat_ms = data;
                CFG_KIND_ENABLE:   enables   = data[2:0];
                CFG_NUM_ROWS:      rows      = data[3:0];
                CFG_COLUMN_COUNT:  cols      = data[3:0];
                default: ;
            endcase
        endfunction

        // Advance one channel by one accepted sample; queue any enabled event
        function void note_sample(input t_in_item s);
            t_out_item ev;
            bit        matrix;
            bit        fire;
            bit [2:0]  col;
            bit [31:0] t;
            bit [31:0] elapsed;
            int        ch;
            matrix = (cols != 0);
            col    = s.column;
            t      = s.now_ms;
            fire   = 1'b0;
            if (s.row >= rows || s.row >= LINES)
                return;
            if (matrix) begin
                if (col >= cols || col >= LINES)
                    return;
                ch = int'(col) * int'(rows) + int'(s.row);
            end else begin
                col = 3'd0;
                ch  = int'(s.row);
            end
            if (ch >= CHANNELS)
                return;

            ev.source         = handle;
            ev.event_kind     = EV_DOWN;
            ev.out_row        = s.row;
            ev.out_column     = col;
            ev.column_present = matrix;
            ev.event_tick     = t;
            ev.press_span     = 32'd0;

            // seed a fresh channel without an event
            if (!seen[ch]) begin
                seen[ch]       = 1'b1;
                level[ch]      = s.pressed;
                latest[ch]     = s.pressed;
                changed_at[ch] = t;
                if (s.pressed) begin
                    pressed_at[ch] = t;
                    repeat_at[ch]  = t + {16'd0, repeat_ms};
                end
                return;
            end

            // restart the debounce timer on a raw change
            if (latest[ch] != s.pressed) begin
                latest[ch]     = s.pressed;
                changed_at[ch] = t;
                return;
            end

            if (level[ch] != s.pressed) begin
                elapsed = t - changed_at[ch];
                if (elapsed < {16'd0, settle_ms})
                    return;
                level[ch] = s.pressed;
                if (s.pressed) begin
                    pressed_at[ch] = t;
                    repeat_at[ch]  = t + {16'd0, repeat_ms};
                end else begin
                    ev.event_kind = EV_UP;
                    ev.press_span = t - pressed_at[ch];
                end
                fire = 1'b1;
            end else if (level[ch] && repeat_ms != 0) begin
                // held repeat is due once the wrapped distance turns non-negative
                elapsed = t - repeat_at[ch];
                if (!elapsed[31]) begin
                    repeat_at[ch] = t + {16'd0, repeat_ms};
                    ev.event_kind = EV_HELD;
                    ev.press_span = t - pressed_at[ch];
                    fire          = 1'b1;
                end
            end

            if (fire && enables[ev.event_kind])
                pending_events.push_back(ev);
        endfunction

        function void check_event(input t_out_item got);
            t_out_item due;
            if (pending_events.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected event: kind=%0d row=%0d col=%0d ts=%h dur=%h",
                             got.event_kind, got.out_row, got.out_column,
                             got.event_tick, got.press_span);
                return;
            end
            due = pending_events.pop_front();
            if (got.source !== due.source || got.event_kind !== due.event_kind ||
                got.out_row !== due.out_row || got.out_column !== due.out_column ||
                got.column_present !== due.column_present ||
                got.event_tick !== due.event_tick ||
                got.press_span !== due.press_span) begin
                failures++;
                if (failures <= 10) begin
                    $display("event mismatch, expected src=%0d kind=%0d row=%0d ",
                             due.source, due.event_kind, due.out_row,
                             "col=%0d mtx=%0d ts=%h dur=%h",
                             due.out_column, due.column_present,
                             due.event_tick, due.press_span);
                    $display("                actual   src=%0d kind=%0d row=%0d ",
                             got.source, got.event_kind, got.out_row,
                             "col=%0d mtx=%0d ts=%h dur=%h",
                             got.out_column, got.column_present,
                             got.event_tick, got.press_span);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    key_event_board board;
    t_cfg           cur_cfg;
    bit [31:0]      clock_ms;
    bit             key_down_intent [LINES][LINES];
    int             idle_pct;
    int             stall_pct;
    int             hold_left;
    int             cycle_count;

    key_debounce_hold_repeat dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Take events at the output; stall at random or through a long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_event(o_out_data);
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offer one sample, hold it until transfer, then let the predictor see it
    task automatic push_sample(input t_in_item s);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.note_sample(s);
    endtask

    task automatic send_key(input int row, input int col, input bit lvl, input bit [31:0] t);
        t_in_item s;
        s.row     = 3'(row);
        s.column  = 3'(col);
        s.pressed = lvl;
        s.now_ms  = t;
        push_sample(s);
    endtask

    // Stop offering and wait until every predicted event has come out
    task automatic drain_events();
        i_in_valid <= 1'b0;
        while (board.pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    // Load a full register set while the block is idle
    task automatic apply_setup(input t_cfg c);
        drain_events();
        write_reg(CFG_SOURCE_HANDLE, {13'd0, c.source_handle});
        write_reg(CFG_SETTLE_MS, c.settle_ms);
        write_reg(CFG_REPEAT_MS, c.repeat_ms);
        write_reg(CFG_KIND_ENABLE, {13'd0, c.kind_enable});
        write_reg(CFG_NUM_ROWS, {12'd0, c.num_rows});
        write_reg(CFG_COLUMN_COUNT, {12'd0, c.column_count});
        i_cfg_valid <= 1'b0;
        cur_cfg = c;
    endtask

    // Mostly well-formed press/release traffic with bounce, plus stray
    // addresses and random clock jumps
    function automatic t_in_item random_sample(input int step_max);
        t_in_item s;
        int       pick;
        int       key_col;
        bit       bounce;
        pick      = $urandom_range(99);
        s.row     = 3'($urandom_range(7));
        s.column  = 3'($urandom_range(7));
        s.pressed = 1'($urandom_range(1));
        if (pick < 8) begin
            clock_ms = clock_ms + $urandom_range(step_max);
            s.now_ms = clock_ms;
            return s;
        end
        if (pick < 14) begin
            clock_ms = $urandom();
            s.now_ms = clock_ms;
            return s;
        end
        s.row = 3'($urandom_range(cur_cfg.num_rows - 1));
        if (cur_cfg.column_count != 0)
            s.column = 3'($urandom_range(cur_cfg.column_count - 1));
        key_col = (cur_cfg.column_count != 0) ? int'(s.column) : 0;
        if ($urandom_range(99) < 10)
            key_down_intent[s.row][key_col] = ~key_down_intent[s.row][key_col];
        bounce    = ($urandom_range(99) < 8);
        s.pressed = key_down_intent[s.row][key_col] ^ bounce;
        clock_ms  = clock_ms + $urandom_range(step_max);
        s.now_ms  = clock_ms;
        return s;
    endfunction

    task automatic run_phase(input t_cfg c, input int count, input int idle,
                             input int stall, input bit squeeze);
        int step_max;
        apply_setup(c);
        idle_pct  = idle;
        stall_pct = stall;
        step_max  = c.settle_ms / 2 + 3;
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == 60)
                hold_left = 300;
            if (squeeze && n == 200)
                drain_events();
            push_sample(random_sample(step_max));
        end
    endtask

    // Cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        board     = new();
        cur_cfg   = {RST_SOURCE_HANDLE, RST_SETTLE_MS, RST_REPEAT_MS,
                     RST_KIND_ENABLE, RST_NUM_ROWS, RST_COLUMN_COUNT};
        clock_ms  = 32'd0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_left = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: direct mode, 20 ms debounce, no repeat
        send_key(0, 0, 1'b1, 32'd100);
        send_key(0, 0, 1'b1, 32'd110);
        send_key(0, 0, 1'b0, 32'd115);
        send_key(0, 0, 1'b0, 32'd134);
        send_key(0, 0, 1'b0, 32'd135);
        // press across the tick wrap
        send_key(7, 0, 1'b0, 32'hFFFF_FFF0);
        send_key(7, 0, 1'b1, 32'hFFFF_FFF8);
        send_key(7, 0, 1'b1, 32'h0000_000C);
        send_key(7, 7, 1'b1, 32'h0000_0010);
        send_key(7, 0, 1'b0, 32'h0000_0020);
        send_key(7, 0, 1'b0, 32'h0000_0034);

        // Matrix 3x2, zero debounce, 5 ms repeat
        apply_setup('{3'd5, 16'd0, 16'd5, 3'd7, 4'd3, 4'd2});
        send_key(2, 1, 1'b1, 32'd1000);
        send_key(3, 0, 1'b1, 32'd1001);
        send_key(0, 2, 1'b1, 32'd1002);
        send_key(2, 1, 1'b1, 32'd1004);
        send_key(2, 1, 1'b1, 32'd1005);
        send_key(2, 1, 1'b0, 32'd1006);
        send_key(2, 1, 1'b0, 32'd1006);
        send_key(2, 1, 1'b1, 32'd1007);
        send_key(2, 1, 1'b1, 32'd1007);

        // Only UP enabled: the due repeat is swallowed but still rescheduled
        apply_setup('{3'd5, 16'd0, 16'd5, 3'd2, 4'd3, 4'd2});
        send_key(2, 1, 1'b1, 32'd1012);
        send_key(2, 1, 1'b0, 32'd1013);
        send_key(2, 1, 1'b0, 32'd1013);

        // Random phases
        clock_ms = 32'd5000;
        run_phase('{3'd3, 16'd5, 16'd7, 3'd7, 4'd4, 4'd0}, 250, 0, 0, 1'b0);
        run_phase('{3'd7, 16'd0, 16'd1, 3'd7, 4'd8, 4'd8}, 250, 84, 0, 1'b0);
        run_phase('{3'd1, 16'd65535, 16'd65535, 3'd5, 4'd1, 4'd1}, 200, 0, 84, 1'b0);
        run_phase('{3'd6, 16'd3, 16'd2, 3'd7, 4'd2, 4'd3}, 300, 21, 21, 1'b1);
        clock_ms = 32'hFFFF_F000;
        run_phase('{3'd2, 16'd10, 16'd0, 3'd3, 4'd8, 4'd0}, 250, 0, 0, 1'b0);
        run_phase('{3'd4, 16'd1, 16'd4, 3'd6, 4'd5, 4'd7}, 200, 84, 0, 1'b0);
        clock_ms = 32'hFFFF_0000;
        run_phase('{3'd0, 16'd65535, 16'd3, 3'd7, 4'd8, 4'd8}, 200, 0, 84, 1'b0);
        run_phase('{3'd5, 16'd0, 16'd0, 3'd1, 4'd1, 4'd0}, 150, 21, 21, 1'b0);
        run_phase('{3'd7, 16'd2, 16'd1, 3'd0, 4'd8, 4'd8}, 50, 0, 0, 1'b0);

        drain_events();
        if (board.failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
